FILE: design/wgm_pkg.sv
`default_nettype none

package wgm_pkg;

    // Default pattern store depth.
    localparam int MAX_PATTERN_DEF = 64;

    // Pattern metacharacters.
    localparam logic [7:0] ANY_ONE = 8'h3F;  // '?'
    localparam logic [7:0] ANY_RUN = 8'h2A;  // '*'

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TEXT   = 2'd1,
        OP_END    = 2'd2,
        OP_CLEAR  = 2'd3
    } wgm_op_t;

    typedef struct packed {
        wgm_op_t    op;
        logic [7:0] character;
    } wgm_in_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } wgm_out_t;

    // Per-transaction control broadcast to every cell.
    typedef struct packed {
        logic       step;         // an input transaction is taken this cycle
        logic       restart;      // start a new text (append, end, clear)
        logic       append;
        logic       clear;
        logic       fold_case;
        logic [7:0] character;    // raw byte, stored on append
        logic [7:0] text_folded;  // text byte after case fold
    } wgm_ctl_t;

    function automatic logic [7:0] wgm_fold(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= UPPER_A && c <= UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/wgm_cell.sv
`default_nettype none

// One pattern position: stored byte, in-use bit and active bit.
module wgm_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wgm_pkg::wgm_ctl_t ctl,
    input  wire logic              use_in,     // left neighbor in use
    input  wire logic              hit_in,     // left neighbor consumed a byte into here
    input  wire logic              close_in,   // closure carried from the left
    output logic                   use_out,
    output logic                   hit_out,
    output logic                   close_out
);

    logic       use_reg, use_next;
    logic       act_reg, act_next;
    logic [7:0] byte_reg, byte_next;
    logic       write_here;
    logic       is_star, is_any, is_match;
    logic       stay;

    always_comb
    begin
        write_here = ctl.append && use_in && !use_reg;
        use_next   = ctl.clear ? 1'b0 : (use_reg || write_here);
        byte_next  = write_here ? ctl.character : byte_reg;

        is_star  = (byte_next == wgm_pkg::ANY_RUN);
        is_any   = (byte_next == wgm_pkg::ANY_ONE);
        is_match = is_any ||
                   (wgm_pkg::wgm_fold(byte_next, ctl.fold_case) == ctl.text_folded);

        if (ctl.restart)
        begin
            stay    = 1'b0;
            hit_out = 1'b0;
        end
        else
        begin
            stay    = use_reg && act_reg && is_star;
            hit_out = use_reg && act_reg && !is_star && is_match;
        end

        act_next  = stay || hit_in || close_in;
        // unused positions pass closure through so the end bit tracks position len
        close_out = act_next && (!use_next || is_star);
    end

    assign use_out = use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg <= 1'b0;
            act_reg <= 1'b1;
        end
        else if (ctl.step)
        begin
            use_reg <= use_next;
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/wildcard_glob_matcher.sv
// A result is registered onto out_data in the cycle after its end-of-text transaction.
// Throughput: one input transaction per cycle; OP_END waits while the output is stalled.
// The cycle time is set by the star-closure carry that ripples through MAX_PATTERN cells.
// Reset: empty pattern, no overflow, fold_case = 1, a new empty text started,
// output register empty.
`default_nettype none

module wildcard_glob_matcher #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire wgm_pkg::wgm_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output wgm_pkg::wgm_out_t     out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data
);

    // ------------------------------------------------------------------
    // Configuration: fold_case, always writable.
    // ------------------------------------------------------------------
    logic fold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fold_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input handshake. Only an end-of-text transaction produces a result,
    // so everything else is taken even while the output register is full.
    // ------------------------------------------------------------------
    logic               in_take;
    logic               is_end;
    wgm_pkg::wgm_ctl_t  ctl;

    assign is_end   = (in_data.op == wgm_pkg::OP_END);
    assign in_ready = !out_valid || out_ready || !is_end;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        ctl.step        = in_take;
        ctl.restart     = (in_data.op != wgm_pkg::OP_TEXT);
        ctl.append      = (in_data.op == wgm_pkg::OP_APPEND);
        ctl.clear       = (in_data.op == wgm_pkg::OP_CLEAR);
        ctl.fold_case   = fold_reg;
        ctl.character   = in_data.character;
        ctl.text_folded = wgm_pkg::wgm_fold(in_data.character, fold_reg);
    end

    // ------------------------------------------------------------------
    // Cell row. use is a thermometer code of the pattern length; the
    // first unused cell takes the next appended byte. hit carries a
    // consumed text byte one position right; close is the star-closure
    // carry (stars and unused cells propagate it).
    // ------------------------------------------------------------------
    logic [MAX_PATTERN:0] use_chain;
    logic [MAX_PATTERN:0] hit_chain;
    logic [MAX_PATTERN:0] close_chain;

    assign use_chain[0] = 1'b1;
    assign hit_chain[0] = ctl.restart;   // restart activates position zero
    assign close_chain[0] = 1'b0;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        wgm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .use_in    (use_chain[i]),
            .hit_in    (hit_chain[i]),
            .close_in  (close_chain[i]),
            .use_out   (use_chain[i+1]),
            .hit_out   (hit_chain[i+1]),
            .close_out (close_chain[i+1])
        );
    end

    // End bit: position MAX_PATTERN, or through unused cells, position len.
    logic end_reg, end_next;
    logic ovf_reg, ovf_next;
    logic full;

    assign full     = use_chain[MAX_PATTERN];
    assign end_next = hit_chain[MAX_PATTERN] || close_chain[MAX_PATTERN];

    always_comb
    begin
        ovf_next = ovf_reg;
        if (ctl.clear)
        begin
            ovf_next = 1'b0;
        end
        else if (ctl.append && full)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg <= 1'b1;
            ovf_reg <= 1'b0;
        end
        else if (in_take)
        begin
            end_reg <= end_next;
            ovf_reg <= ovf_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic              out_valid_reg, out_valid_next;
    wgm_pkg::wgm_out_t out_data_reg, out_data_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_take && is_end)
        begin
            out_valid_next                 = 1'b1;
            out_data_next.matched          = end_reg && !ovf_reg;
            out_data_next.pattern_overflow = ovf_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // Length stays a thermometer code from cell zero (one extra bit for a full store).
    a_use_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, use_chain} + {{(MAX_PATTERN + 1){1'b0}}, 1'b1}))
        else $error("pattern length bits not contiguous");

    // A clear empties every cell.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && ctl.clear) |=> (use_chain[MAX_PATTERN:1] == '0))
        else $error("cells still in use after clear");

    // Overflow only with a full store.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> full)
        else $error("overflow flag set with free cells");

    // An end-of-text transaction always leaves a result behind.
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && is_end) |=> (out_valid_reg && !(out_data_reg.matched &&
                                                    out_data_reg.pattern_overflow)))
        else $error("end of text without a valid result");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_wildcard_glob_matcher.sv
`default_nettype none

module tb_wildcard_glob_matcher;

    localparam int MAXP = wgm_pkg::MAX_PATTERN_DEF;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    wgm_pkg::wgm_in_t  in_data;
    logic              out_valid;
    logic              out_ready = 1'b0;
    wgm_pkg::wgm_out_t out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;

    wildcard_glob_matcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Glob predictor: pattern bytes, the set of live pattern positions
    // (bit i set = the text so far can consume the first i pattern bytes),
    // sticky overflow and the case-fold setting.
    // ------------------------------------------------------------------
    logic [7:0]    glob_pat [MAXP];
    int            glob_len;
    logic [MAXP:0] live_pos;
    logic          glob_ovf;
    logic          fold_on;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        if (fold_on && c >= "A" && c <= "Z")
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // A live star also makes the position after it live; ascending order
    // carries through runs of stars.
    function automatic logic [MAXP:0] star_close(input logic [MAXP:0] v);
        for (int i = 0; i < glob_len; i++)
        begin
            if (v[i] && glob_pat[i] == wgm_pkg::ANY_RUN)
            begin
                v[i + 1] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic void begin_text();
        live_pos = '0;
        live_pos[0] = 1'b1;
        live_pos = star_close(live_pos);
    endfunction

    function automatic void consume_byte(input logic [7:0] c);
        logic [MAXP:0] advanced;
        advanced = '0;
        for (int i = 0; i < glob_len; i++)
        begin
            if (live_pos[i])
            begin
                if (glob_pat[i] == wgm_pkg::ANY_RUN)
                begin
                    advanced[i] = 1'b1;
                end
                else if (glob_pat[i] == wgm_pkg::ANY_ONE ||
                         lower_byte(glob_pat[i]) == lower_byte(c))
                begin
                    advanced[i + 1] = 1'b1;
                end
            end
        end
        live_pos = star_close(advanced);
    endfunction

    function automatic void glob_reset();
        glob_len = 0;
        glob_ovf = 1'b0;
        fold_on = 1'b1;
        begin_text();
    endfunction

    // Advances the predictor by one transaction; returns 1 with the verdict
    // when the transaction ends a text.
    function automatic bit glob_step(input wgm_pkg::wgm_in_t t,
                                     output wgm_pkg::wgm_out_t verdict);
        verdict = '0;
        case (t.op)
            wgm_pkg::OP_APPEND:
            begin
                if (glob_len < MAXP)
                begin
                    glob_pat[glob_len] = t.character;
                    glob_len++;
                end
                else
                begin
                    glob_ovf = 1'b1;
                end
                begin_text();
                return 1'b0;
            end
            wgm_pkg::OP_TEXT:
            begin
                consume_byte(t.character);
                return 1'b0;
            end
            wgm_pkg::OP_END:
            begin
                verdict.matched = live_pos[glob_len] && !glob_ovf;
                verdict.pattern_overflow = glob_ovf;
                begin_text();
                return 1'b1;
            end
            default:
            begin
                glob_len = 0;
                glob_ovf = 1'b0;
                begin_text();
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Verdicts waiting for the output side, plus run statistics.
    // ------------------------------------------------------------------
    wgm_pkg::wgm_out_t verdict_q[$];
    wgm_pkg::wgm_out_t want;
    int errors = 0;
    int n_in;
    int n_verdicts = 0;
    int n_hits = 0;
    int n_ovf = 0;
    int n_cfg;

    // Idle controls: percent chance of an input gap per transaction, and of an output stall.
    int  gap_pct;
    int  stall_pct;
    bit  quiet;
    int  stall_left = 0;

    // Output side: random stall bursts on out_ready.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(99) < stall_pct)
        begin
            stall_left = $urandom_range(6, 1) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result checker: every accepted result against the oldest verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result with nothing expected: matched %0d pattern_overflow %0d",
                       out_data.matched, out_data.pattern_overflow);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                n_verdicts++;
                if (want.matched)
                begin
                    n_hits++;
                end
                if (want.pattern_overflow)
                begin
                    n_ovf++;
                end
                if (out_data.matched !== want.matched)
                begin
                    $error("matched: expected %0d, got %0d", want.matched, out_data.matched);
                    errors++;
                end
                if (out_data.pattern_overflow !== want.pattern_overflow)
                begin
                    $error("pattern_overflow: expected %0d, got %0d",
                           want.pattern_overflow, out_data.pattern_overflow);
                    errors++;
                end
            end
        end
    end

    // One input transaction, optionally after an idle burst. in_valid is left
    // high on return so back-to-back transactions follow without a gap; callers
    // lower it before any other wait.
    task automatic send_txn(input wgm_pkg::wgm_in_t t, input bit typed,
                            input wgm_pkg::wgm_out_t typed_res);
        wgm_pkg::wgm_out_t res;
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        n_in++;
        if (glob_step(t, res))
        begin
            verdict_q = {verdict_q, (typed ? typed_res : res)};
        end
    endtask

    // fold_case write, only with the matcher drained.
    task automatic write_fold(input logic v);
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        // clear/append/text transactions leave nothing to wait on; give them
        // time to settle past the registered pipeline
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        fold_on = v;
        n_cfg++;
    endtask

    function automatic wgm_pkg::wgm_in_t mk(input wgm_pkg::wgm_op_t op, input logic [7:0] c);
        wgm_pkg::wgm_in_t t;
        t.op = op;
        t.character = c;
        return t;
    endfunction

    function automatic logic [7:0] letter();
        case ($urandom_range(3))
            0:       return "a";
            1:       return "b";
            2:       return "A";
            default: return "B";
        endcase
    endfunction

    function automatic logic [7:0] pattern_byte();
        int r;
        r = $urandom_range(99);
        if (r < 20)
        begin
            return wgm_pkg::ANY_RUN;
        end
        if (r < 35)
        begin
            return wgm_pkg::ANY_ONE;
        end
        if (r < 85)
        begin
            return letter();
        end
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 70)
        begin
            return letter();
        end
        if (r < 80)
        begin
            return wgm_pkg::ANY_RUN;
        end
        if (r < 85)
        begin
            return wgm_pkg::ANY_ONE;
        end
        return 8'($urandom);
    endfunction

    // Random stimulus: mostly clear + pattern + texts built to walk the
    // pattern (so matches are common), some purely random texts, a few
    // long patterns that come near, fill or overflow the store, texts cut by an
    // append, texts left unterminated, and raw noise.
    task automatic random_block(input int budget);
        wgm_pkg::wgm_in_t seq[$];
        logic [7:0]       pat[$];
        logic [7:0]       txt[$];
        logic [7:0]       c;
        int               plen;
        int               cut;
        int               r;
        while (budget > 0)
        begin
            seq.delete();
            if ($urandom_range(99) < 10)
            begin
                repeat ($urandom_range(8, 1))
                begin
                    seq = {seq, mk(wgm_pkg::wgm_op_t'($urandom_range(3)), 8'($urandom))};
                end
            end
            else
            begin
                if ($urandom_range(99) < 85)
                begin
                    pat.delete();
                    seq = {seq, mk(wgm_pkg::OP_CLEAR, 8'($urandom))};
                end
                r = $urandom_range(99);
                if (r < 80)
                begin
                    plen = $urandom_range(8);
                end
                else if (r < 90)
                begin
                    plen = $urandom_range(20, 9);
                end
                else
                begin
                    plen = $urandom_range(70, 60);
                end
                repeat (plen)
                begin
                    c = pattern_byte();
                    pat = {pat, c};
                    seq = {seq, mk(wgm_pkg::OP_APPEND, c)};
                end
                repeat ($urandom_range(3, 1))
                begin
                    txt.delete();
                    if ($urandom_range(1))
                    begin
                        foreach (pat[j])
                        begin
                            if (pat[j] == wgm_pkg::ANY_RUN)
                            begin
                                repeat ($urandom_range(2)) txt = {txt, text_byte()};
                            end
                            else if (pat[j] == wgm_pkg::ANY_ONE)
                            begin
                                txt = {txt, 8'($urandom)};
                            end
                            else
                            begin
                                c = pat[j];
                                // swap letter case now and then to hit the fold
                                if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z"
                                    && $urandom_range(2) == 0)
                                begin
                                    c = c ^ 8'h20;
                                end
                                txt = {txt, c};
                            end
                        end
                        if ($urandom_range(4) == 0 && txt.size() > 0)
                        begin
                            txt[$urandom_range(txt.size() - 1)] = text_byte();
                        end
                    end
                    else
                    begin
                        repeat ($urandom_range(10)) txt = {txt, text_byte()};
                    end
                    cut = ($urandom_range(9) == 0) ? $urandom_range(txt.size()) : -1;
                    foreach (txt[j])
                    begin
                        if (j == cut)
                        begin
                            c = pattern_byte();
                            pat = {pat, c};
                            seq = {seq, mk(wgm_pkg::OP_APPEND, c)};
                        end
                        seq = {seq, mk(wgm_pkg::OP_TEXT, txt[j])};
                    end
                    if ($urandom_range(19) != 0)
                    begin
                        seq = {seq, mk(wgm_pkg::OP_END, 8'($urandom))};
                    end
                end
            end
            foreach (seq[j])
            begin
                send_txn(seq[j], 1'b0, '0);
                budget--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table. Rows with a typed verdict are obvious cases; the
    // others go through the predictor. Runs with fold_case at reset (1).
    // ------------------------------------------------------------------
    typedef struct packed {
        wgm_pkg::wgm_op_t op;
        logic [7:0]       ch;
        logic             typed;
        logic             m;
        logic             o;
    } plan_row_t;

    localparam int PLAN_LEN = 22;

    plan_row_t plan [PLAN_LEN] = '{
        '{wgm_pkg::OP_END,    8'h00,            1'b1, 1'b1, 1'b0},  // empty pattern, empty text
        '{wgm_pkg::OP_TEXT,   "x",              1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_END,    8'hFF,            1'b1, 1'b0, 1'b0},  // empty pattern, one byte
        '{wgm_pkg::OP_APPEND, wgm_pkg::ANY_RUN, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_END,    8'h00,            1'b1, 1'b1, 1'b0},  // lone star, empty text
        '{wgm_pkg::OP_APPEND, "A",              1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_TEXT,   "Z",              1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_TEXT,   "a",              1'b0, 1'b0, 1'b0},  // folds against 'A'
        '{wgm_pkg::OP_END,    8'h00,            1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_TEXT,   "a",              1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_CLEAR,  8'hFF,            1'b0, 1'b0, 1'b0},  // drops the partial text
        '{wgm_pkg::OP_END,    8'h00,            1'b1, 1'b1, 1'b0},
        '{wgm_pkg::OP_APPEND, 8'hFF,            1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_TEXT,   8'hFF,            1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_APPEND, wgm_pkg::ANY_ONE, 1'b0, 1'b0, 1'b0},  // restarts the text
        '{wgm_pkg::OP_TEXT,   8'hFF,            1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_TEXT,   wgm_pkg::ANY_ONE, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_END,    8'h00,            1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_CLEAR,  8'h00,            1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_APPEND, "a",              1'b0, 1'b0, 1'b0},
        '{wgm_pkg::OP_TEXT,   wgm_pkg::ANY_RUN, 1'b0, 1'b0, 1'b0},  // star in text is data
        '{wgm_pkg::OP_END,    8'h00,            1'b0, 1'b0, 1'b0}
    };

    initial
    begin
        wgm_pkg::wgm_out_t typed_res;
        int                waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        n_in = 0;
        n_cfg = 0;
        gap_pct = 25;
        stall_pct = 25;
        quiet = 1'b0;
        glob_reset();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            typed_res.matched = plan[k].m;
            typed_res.pattern_overflow = plan[k].o;
            send_txn(mk(plan[k].op, plan[k].ch), plan[k].typed, typed_res);
        end

        // Random phases alternate fold_case 0/1; phase 2 (gap and stall rates
        // zero) and the last phase (quiet) run with no idling.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_fold((ph % 2) != 0);
            gap_pct = (ph == 2) ? 0 : 25;
            stall_pct = (ph == 2) ? 0 : 25;
            quiet = (ph == 5);
            random_block(320);
        end

        in_valid <= 1'b0;
        waited = 0;
        while (verdict_q.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d expected results never arrived", verdict_q.size());
        end

        $display("ran %0d transactions in, %0d results checked (%0d matches, %0d overflowed)",
                 n_in, n_verdicts, n_hits, n_ovf);
        $display("fold_case written %0d times, patterns up to past the %0d-byte store",
                 n_cfg, MAXP);
        if (errors == 0 && verdict_q.size() == 0)
        begin
            $display("tb_wildcard_glob_matcher passed");
        end
        else
        begin
            $display("tb_wildcard_glob_matcher failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_wildcard_glob_matcher failed");
        $finish;
    end

endmodule

`default_nettype wire
